### design/irdf_pkg.sv
// IR ring direction finder: shared constants, types, CORDIC tables and helpers.
// No dependencies; every other design file uses this package.
`default_nettype none

package irdf_pkg;

  localparam int SENSORS_MAX    = 16;
  localparam int SENSORS_DEF    = 16;
  localparam int PULSE_STEP_DEF = 1;
  localparam int WIDTH_BITS_DEF = 16;

  localparam int LEVEL_W   = 16;
  localparam int ACTIVE_W  = 5;
  localparam int IDX_W     = 4;
  localparam int MAXW_W    = 16;
  localparam int VEC_W     = 21;
  localparam int MAG_W     = 21;
  localparam int ANGLE_W   = 15;
  localparam int WINDOW_W  = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;
  localparam logic REG_WINDOW = 1'b0;

  localparam int UNIT_W  = 16;
  localparam int STEPS   = 20;
  localparam int STEP_W  = 5;
  localparam int SQ_W    = 42;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int ROT_W   = 34;
  localparam int Z_W     = 26;

  localparam longint DEG90    = 64'sd5898240;
  localparam longint DEG180   = 64'sd11796480;
  localparam longint DEG270   = 64'sd17694720;
  localparam longint DEG360   = 64'sd23592960;
  localparam longint INV_GAIN = 64'sd652032874;
  localparam int VEC_MAX   = 1048575;
  localparam int MAG_MAX   = 2097151;
  localparam int ANGLE_MAX = 11520;

  localparam int ATN [STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117306, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic signed [UNIT_W-1:0] x;
    logic signed [UNIT_W-1:0] y;
  } unit_t;

  typedef struct packed {
    logic              accum;
    logic              scan;
    logic [IDX_W-1:0]  idx;
    logic              round;
    logic              square;
    logic              iter_init;
    logic              iter_step;
    logic              rot_step;
    logic [STEP_W-1:0] step;
    logic              load;
  } cmd_t;

  function automatic longint shr_tz_l(longint v, int k);
    if (v < 0) return -((-v) >>> k);
    return v >>> k;
  endfunction

  function automatic longint shr_rnd_l(longint v, int k);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (k - 1))) >>> k;
    return (v < 0) ? -m : m;
  endfunction

  // elaboration-time unit vector of one sensor angle (2^-16 degree units)
  function automatic unit_t unit_vec(longint ang);
    longint a, c, s, z, nc, ns;
    logic   flip;
    unit_t  u;
    a = ang;
    c = INV_GAIN;
    s = 0;
    flip = 1'b0;
    if (a > DEG270) begin
      a = a - DEG360;
    end else if (a > DEG90) begin
      a = a - DEG180;
      flip = 1'b1;
    end
    z = a;
    for (int k = 0; k < STEPS; k++) begin
      if (z >= 0) begin
        nc = c - shr_tz_l(s, k);
        ns = s + shr_tz_l(c, k);
        z  = z - longint'(ATN[k]);
      end else begin
        nc = c + shr_tz_l(s, k);
        ns = s - shr_tz_l(c, k);
        z  = z + longint'(ATN[k]);
      end
      c = nc;
      s = ns;
    end
    if (flip) begin
      c = -c;
      s = -s;
    end
    u.x = UNIT_W'(shr_rnd_l(s, 16));
    u.y = UNIT_W'(shr_rnd_l(c, 16));
    return u;
  endfunction

  // arithmetic shift that truncates toward zero
  function automatic logic signed [ROT_W-1:0] shr_tz(logic signed [ROT_W-1:0] v,
                                                     logic [STEP_W-1:0] k);
    logic [ROT_W-1:0] m;
    m = v[ROT_W-1] ? ROT_W'(-v) : v;
    m = m >> k;
    return v[ROT_W-1] ? -$signed(m) : $signed(m);
  endfunction

endpackage

`default_nettype wire

### design/irdf_if.sv
// Valid/ready channel interfaces for the IR ring direction finder.
// Depends on irdf_pkg for field widths.
`default_nettype none

interface irdf_in_if;
  logic                         valid;
  logic                         ready;
  logic [irdf_pkg::LEVEL_W-1:0] sensor_levels;
  modport source (output valid, output sensor_levels, input ready);
  modport sink (input valid, input sensor_levels, output ready);
endinterface

interface irdf_out_if;
  logic                                valid;
  logic                                ready;
  logic [irdf_pkg::ACTIVE_W-1:0]       active_count;
  logic [irdf_pkg::IDX_W-1:0]          max_sensor;
  logic [irdf_pkg::MAXW_W-1:0]         max_width;
  logic signed [irdf_pkg::VEC_W-1:0]   vector_x;
  logic signed [irdf_pkg::VEC_W-1:0]   vector_y;
  logic [irdf_pkg::MAG_W-1:0]          magnitude;
  logic signed [irdf_pkg::ANGLE_W-1:0] angle;
  modport source (output valid, output active_count, output max_sensor, output max_width,
                  output vector_x, output vector_y, output magnitude, output angle,
                  input ready);
  modport sink (input valid, input active_count, input max_sensor, input max_width,
                input vector_x, input vector_y, input magnitude, input angle,
                output ready);
endinterface

`default_nettype wire

### design/irdf_dp.sv
// Datapath: width counters, sensor scan, vector sums, square root and CORDIC angle.
// Driven by irdf_ctrl through irdf_pkg::cmd_t; uses irdf_pkg constants and helpers.
`default_nettype none

module irdf_dp #(
  parameter int SENSORS    = irdf_pkg::SENSORS_DEF,
  parameter int PULSE_STEP = irdf_pkg::PULSE_STEP_DEF,
  parameter int WIDTH_BITS = irdf_pkg::WIDTH_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire irdf_pkg::cmd_t                      cmd,
  input  wire logic [irdf_pkg::LEVEL_W-1:0]        levels,
  output logic [irdf_pkg::ACTIVE_W-1:0]            active_count,
  output logic [irdf_pkg::IDX_W-1:0]               max_sensor,
  output logic [irdf_pkg::MAXW_W-1:0]              max_width,
  output logic signed [irdf_pkg::VEC_W-1:0]        vector_x,
  output logic signed [irdf_pkg::VEC_W-1:0]        vector_y,
  output logic [irdf_pkg::MAG_W-1:0]               magnitude,
  output logic signed [irdf_pkg::ANGLE_W-1:0]      angle
);

  localparam int SIDX_W = $clog2(SENSORS);
  localparam int PROD_W = WIDTH_BITS + irdf_pkg::UNIT_W + 1;
  localparam int SUM_W  = PROD_W + 4;
  localparam int VEC_W  = irdf_pkg::VEC_W;
  localparam int MAGV_W = VEC_W - 1;
  localparam int SQ_W   = irdf_pkg::SQ_W;
  localparam int ROT_W  = irdf_pkg::ROT_W;
  localparam int Z_W    = irdf_pkg::Z_W;
  localparam logic [WIDTH_BITS-1:0] WMAX = {WIDTH_BITS{1'b1}};
  localparam logic [WIDTH_BITS-1:0] WSTEP = WIDTH_BITS'(PULSE_STEP);

  logic [WIDTH_BITS-1:0] cnt_r [SENSORS];
  logic signed [irdf_pkg::UNIT_W-1:0] ux_tab [SENSORS];
  logic signed [irdf_pkg::UNIT_W-1:0] uy_tab [SENSORS];

  for (genvar g = 0; g < SENSORS; g++) begin : g_unit
    localparam longint ANG = longint'(g) * irdf_pkg::DEG360 / SENSORS;
    localparam irdf_pkg::unit_t U = irdf_pkg::unit_vec(ANG);
    assign ux_tab[g] = U.x;
    assign uy_tab[g] = U.y;

    always_ff @(posedge clk) begin
      if (!rst_n || cmd.load) begin
        cnt_r[g] <= '0;
      end else if (cmd.accum && !levels[g]) begin
        cnt_r[g] <= (WMAX - cnt_r[g] < WSTEP) ? WMAX : cnt_r[g] + WSTEP;
      end
    end
  end

  // scan of the counters
  logic [SIDX_W-1:0]     sidx;
  logic [WIDTH_BITS-1:0] w;
  logic                  scan_first;
  logic [irdf_pkg::ACTIVE_W-1:0] active_r;
  logic [WIDTH_BITS-1:0] best_r;
  logic [irdf_pkg::IDX_W-1:0] best_i_r;
  logic signed [PROD_W-1:0] prodx_r, prody_r;
  logic                  prod_vld_r;
  logic signed [SUM_W-1:0] sx_r, sy_r;

  assign sidx = cmd.idx[SIDX_W-1:0];
  assign w = cnt_r[sidx];
  assign scan_first = cmd.scan && (sidx == '0);

  always_ff @(posedge clk) begin
    prod_vld_r <= cmd.scan;
    if (cmd.scan) begin
      prodx_r <= $signed({1'b0, w}) * ux_tab[sidx];
      prody_r <= $signed({1'b0, w}) * uy_tab[sidx];
      if (scan_first) begin
        active_r <= irdf_pkg::ACTIVE_W'(w != '0);
        best_r   <= w;
        best_i_r <= '0;
      end else begin
        active_r <= active_r + irdf_pkg::ACTIVE_W'(w != '0);
        if (w > best_r) begin
          best_r   <= w;
          best_i_r <= cmd.idx;
        end
      end
    end
    if (scan_first) begin
      sx_r <= '0;
      sy_r <= '0;
    end else if (prod_vld_r) begin
      sx_r <= sx_r + SUM_W'(prodx_r);
      sy_r <= sy_r + SUM_W'(prody_r);
    end
  end

  function automatic logic signed [VEC_W-1:0] rnd_sat(logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] m;
    logic [SUM_W-1:0] r;
    logic [VEC_W-1:0] s;
    m = v[SUM_W-1] ? SUM_W'(-v) : v;
    r = (m + SUM_W'(8192)) >> 14;
    s = (r > SUM_W'(irdf_pkg::VEC_MAX)) ? VEC_W'(irdf_pkg::VEC_MAX) : r[VEC_W-1:0];
    return v[SUM_W-1] ? -$signed(s) : $signed(s);
  endfunction

  logic signed [VEC_W-1:0] vx_r, vy_r;
  logic [MAGV_W-1:0]   ax, ay;
  logic [2*MAGV_W-1:0] sqx_w, sqy_w;
  logic [SQ_W-1:0] sqx_r, sqy_r;
  logic [SQ_W-1:0] n_r, r_r, bit_r;
  logic [SQ_W:0]   trial;
  logic signed [ROT_W-1:0] a_r, b_r, ta, tb, a0, b0;
  logic signed [Z_W-1:0]   z_r, atn;
  logic                    zero_r;

  // vx, vy are saturated to +-VEC_MAX, so their magnitudes fit MAGV_W bits
  assign ax    = vx_r[VEC_W-1] ? MAGV_W'(-vx_r) : vx_r[MAGV_W-1:0];
  assign ay    = vy_r[VEC_W-1] ? MAGV_W'(-vy_r) : vy_r[MAGV_W-1:0];
  assign sqx_w = ax * ax;
  assign sqy_w = ay * ay;

  assign trial = {1'b0, r_r} + {1'b0, bit_r};
  assign ta  = irdf_pkg::shr_tz(b_r, cmd.step);
  assign tb  = irdf_pkg::shr_tz(a_r, cmd.step);
  assign atn = Z_W'(irdf_pkg::ATN[cmd.step]);
  assign a0  = {{(ROT_W-VEC_W-10){vy_r[VEC_W-1]}}, vy_r, 10'b0};
  assign b0  = {{(ROT_W-VEC_W-10){vx_r[VEC_W-1]}}, vx_r, 10'b0};

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      vx_r <= rnd_sat(sx_r);
      vy_r <= rnd_sat(sy_r);
    end
    if (cmd.square) begin
      sqx_r <= SQ_W'(sqx_w);
      sqy_r <= SQ_W'(sqy_w);
    end
    if (cmd.iter_init) begin
      n_r    <= sqx_r + sqy_r;
      r_r    <= '0;
      bit_r  <= SQ_W'(1) << (SQ_W - 2);
      zero_r <= (vx_r == '0) && (vy_r == '0);
      if (a0 < 0) begin
        if (b0 >= 0) begin
          a_r <= b0;
          b_r <= -a0;
          z_r <= Z_W'(irdf_pkg::DEG90);
        end else begin
          a_r <= -b0;
          b_r <= a0;
          z_r <= -Z_W'(irdf_pkg::DEG90);
        end
      end else begin
        a_r <= a0;
        b_r <= b0;
        z_r <= '0;
      end
    end else if (cmd.iter_step) begin
      if (trial <= {1'b0, n_r}) begin
        n_r <= n_r - trial[SQ_W-1:0];
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
      if (cmd.rot_step) begin
        if (b_r >= 0) begin
          a_r <= a_r + ta;
          b_r <= b_r - tb;
          z_r <= z_r + atn;
        end else begin
          a_r <= a_r - ta;
          b_r <= b_r + tb;
          z_r <= z_r - atn;
        end
      end
    end
  end

  // final rounding of magnitude and angle
  logic [SQ_W-1:0] mag_full;
  logic [Z_W-1:0]  zm, zr;
  logic [irdf_pkg::ANGLE_W-1:0] zc;
  logic signed [irdf_pkg::ANGLE_W-1:0] ang_fin;

  assign mag_full = r_r + SQ_W'(n_r > r_r);
  assign zm = z_r[Z_W-1] ? Z_W'(-z_r) : z_r;
  assign zr = (zm + Z_W'(512)) >> 10;
  assign zc = (zr > Z_W'(irdf_pkg::ANGLE_MAX)) ? irdf_pkg::ANGLE_W'(irdf_pkg::ANGLE_MAX)
                                              : zr[irdf_pkg::ANGLE_W-1:0];
  assign ang_fin = zero_r ? '0 : (z_r[Z_W-1] ? -$signed(zc) : $signed(zc));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      active_count <= active_r;
      max_sensor   <= best_i_r;
      max_width    <= (32'(best_r) > 32'd65535) ? 16'hFFFF : irdf_pkg::MAXW_W'(best_r);
      vector_x     <= vx_r;
      vector_y     <= vy_r;
      magnitude    <= (mag_full > SQ_W'(irdf_pkg::MAG_MAX)) ?
                      irdf_pkg::MAG_W'(irdf_pkg::MAG_MAX) : mag_full[irdf_pkg::MAG_W-1:0];
      angle        <= ang_fin;
    end
  end

endmodule

`default_nettype wire

### design/irdf_ctrl.sv
// Controller: tick counting, window end detection and the post-window sequence.
// Issues irdf_pkg::cmd_t to irdf_dp and owns the handshake valid/ready flags.
`default_nettype none

module irdf_ctrl #(
  parameter int SENSORS = irdf_pkg::SENSORS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  input  wire logic [irdf_pkg::WINDOW_W-1:0]   limit,
  output irdf_pkg::cmd_t                       cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_ROUND, S_SQUARE, S_INIT, S_ITER, S_FINISH
  } state_t;

  localparam logic [irdf_pkg::IDX_W-1:0]  LAST_IDX  = irdf_pkg::IDX_W'(SENSORS - 1);
  localparam logic [irdf_pkg::STEP_W-1:0] LAST_STEP = irdf_pkg::STEP_W'(irdf_pkg::SQ_STEPS - 1);
  localparam logic [irdf_pkg::STEP_W-1:0] ROT_STEPS = irdf_pkg::STEP_W'(irdf_pkg::STEPS);

  state_t                          state_r;
  logic [irdf_pkg::IDX_W-1:0]      idx_r;
  logic [irdf_pkg::STEP_W-1:0]     step_r;
  logic [irdf_pkg::WINDOW_W-1:0]   tick_r;
  logic                            out_valid_r;
  logic                            accept, load, win_end;
  logic [irdf_pkg::WINDOW_W:0]     tick_inc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign load      = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  assign tick_inc  = {1'b0, tick_r} + 1'b1;
  assign win_end   = tick_inc >= {1'b0, limit};

  always_comb begin
    cmd           = '0;
    cmd.accum     = accept;
    cmd.scan      = (state_r == S_SCAN);
    cmd.idx       = idx_r;
    cmd.round     = (state_r == S_ROUND);
    cmd.square    = (state_r == S_SQUARE);
    cmd.iter_init = (state_r == S_INIT);
    cmd.iter_step = (state_r == S_ITER);
    cmd.rot_step  = (state_r == S_ITER) && (step_r < ROT_STEPS);
    cmd.step      = step_r;
    cmd.load      = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      step_r      <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (win_end) begin
              tick_r  <= '0;
              idx_r   <= '0;
              state_r <= S_SCAN;
            end else begin
              tick_r <= tick_inc[irdf_pkg::WINDOW_W-1:0];
            end
          end
        end
        S_SCAN: begin
          if (idx_r == LAST_IDX) begin
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DRAIN:  state_r <= S_ROUND;
        S_ROUND:  state_r <= S_SQUARE;
        S_SQUARE: state_r <= S_INIT;
        S_INIT: begin
          step_r  <= '0;
          state_r <= S_ITER;
        end
        S_ITER: begin
          if (step_r == LAST_STEP) begin
            state_r <= S_FINISH;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_FINISH: begin
          if (load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_iter_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ITER && step_r == LAST_STEP) |=> state_r == S_FINISH)
    else $error("iteration did not finish");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result dropped while stalled");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ready))
    else $error("result overwritten");
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> idx_r <= LAST_IDX)
    else $error("scan index out of range");
`endif

endmodule

`default_nettype wire

### design/ir_ring_direction_finder.sv
// IR ring direction finder top level: config register, controller and datapath.
// Depends on irdf_pkg, irdf_if (irdf_in_if, irdf_out_if), irdf_ctrl and irdf_dp.
//
// Usage:
//   in_if carries one sample tick per item: sensor_levels, bit i low = IR seen.
//   Items are taken one per cycle while no window is being evaluated.
//   After window_ticks items (0 acts as 1) the block scans the SENSORS counters
//   one per cycle, rounds the vector, squares it, then runs a 21-step square
//   root alongside a 20-step CORDIC angle unit. in_ready stays low after the
//   window's last item until the result is loaded; then out_if.valid rises,
//   the result is held in the out_if register and the counters restart.
//   A stalled out_if does not block new items; only a second window end
//   waits for the pending result to be taken.
//   cfg_*: APB-style, window_ticks at byte address 0, pready always high.
//   Reset (rst_n low, synchronous): counters and tick count cleared,
//   window_ticks = 1000, no result pending.
`default_nettype none

module ir_ring_direction_finder #(
  parameter int SENSORS    = irdf_pkg::SENSORS_DEF,
  parameter int PULSE_STEP = irdf_pkg::PULSE_STEP_DEF,
  parameter int WIDTH_BITS = irdf_pkg::WIDTH_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  irdf_in_if.sink                                  in_if,
  irdf_out_if.source                               out_if,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [irdf_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [irdf_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [irdf_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                     cfg_pready
);

  logic [irdf_pkg::WINDOW_W-1:0] window_r;
  logic [irdf_pkg::WINDOW_W-1:0] limit;
  logic                          sel_window;
  irdf_pkg::cmd_t                cmd;

  assign cfg_pready = 1'b1;
  assign sel_window = (cfg_paddr[2] == irdf_pkg::REG_WINDOW);
  assign cfg_prdata = sel_window ? irdf_pkg::CFG_DATA_W'(window_r) : '0;
  assign limit      = (window_r == '0) ? irdf_pkg::WINDOW_W'(1) : window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= irdf_pkg::WINDOW_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_window) begin
      window_r <= cfg_pwdata[irdf_pkg::WINDOW_W-1:0];
    end
  end

  irdf_ctrl #(.SENSORS(SENSORS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .limit     (limit),
    .cmd       (cmd)
  );

  irdf_dp #(
    .SENSORS    (SENSORS),
    .PULSE_STEP (PULSE_STEP),
    .WIDTH_BITS (WIDTH_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .levels       (in_if.sensor_levels),
    .active_count (out_if.active_count),
    .max_sensor   (out_if.max_sensor),
    .max_width    (out_if.max_width),
    .vector_x     (out_if.vector_x),
    .vector_y     (out_if.vector_y),
    .magnitude    (out_if.magnitude),
    .angle        (out_if.angle)
  );

endmodule

`default_nettype wire

### sim/tb_ir_ring_direction_finder.sv
// Testbench for ir_ring_direction_finder: directed table, then random sensor ticks
// over several window lengths, each result checked against an in-bench predictor or the table's expected heading.
// Depends on irdf_pkg, irdf_if and the design top level.
`default_nettype none

module tb_ir_ring_direction_finder;

  typedef struct {
    logic [irdf_pkg::ACTIVE_W-1:0]       active;
    logic [irdf_pkg::IDX_W-1:0]          sensor;
    logic [irdf_pkg::MAXW_W-1:0]         width;
    logic signed [irdf_pkg::VEC_W-1:0]   vx;
    logic signed [irdf_pkg::VEC_W-1:0]   vy;
    logic [irdf_pkg::MAG_W-1:0]          mag;
    logic signed [irdf_pkg::ANGLE_W-1:0] ang;
  } heading_t;

  typedef struct {
    logic [irdf_pkg::LEVEL_W-1:0] levels;
    bit                           typed;
    heading_t                     want;
  } row_t;

  localparam heading_t DARK = '{0, 0, 0, 0, 0, 0, 0};
  localparam longint WIDTH_SAT = 65535;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [irdf_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [irdf_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [irdf_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  irdf_in_if  in_if ();
  irdf_out_if out_if ();

  ir_ring_direction_finder DUT (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor state
  longint ring_x [irdf_pkg::SENSORS_MAX];
  longint ring_y [irdf_pkg::SENSORS_MAX];
  longint pulse_widths [irdf_pkg::SENSORS_MAX];
  longint ticks_seen;
  longint window_len;
  heading_t heading_q [$];
  int errors = 0;
  bit hold_req = 0;

  function automatic longint trunc_shr(longint v, int k);
    if (v < 0) return -((-v) >>> k);
    return v >>> k;
  endfunction

  function automatic longint round_shr(longint v, int k);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) <<< (k - 1))) >>> k;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic build_ring();
    longint a, c, s, z, nc, ns;
    bit flip;
    for (int i = 0; i < irdf_pkg::SENSORS_MAX; i++) begin
      a = longint'(i) * irdf_pkg::DEG360 / irdf_pkg::SENSORS_DEF;
      c = irdf_pkg::INV_GAIN;
      s = 0;
      flip = 0;
      if (a > irdf_pkg::DEG270) a -= irdf_pkg::DEG360;
      else if (a > irdf_pkg::DEG90) begin
        a -= irdf_pkg::DEG180;
        flip = 1;
      end
      z = a;
      for (int k = 0; k < irdf_pkg::STEPS; k++) begin
        if (z >= 0) begin
          nc = c - trunc_shr(s, k); ns = s + trunc_shr(c, k); z -= irdf_pkg::ATN[k];
        end else begin
          nc = c + trunc_shr(s, k); ns = s - trunc_shr(c, k); z += irdf_pkg::ATN[k];
        end
        c = nc;
        s = ns;
      end
      if (flip) begin
        c = -c;
        s = -s;
      end
      ring_x[i] = round_shr(s, 16);
      ring_y[i] = round_shr(c, 16);
    end
  endtask

  function automatic longint sqrt_nearest(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    if (n > r) r++;
    return longint'(r);
  endfunction

  function automatic longint bearing(longint vx, longint vy);
    longint a, b, z, t, na, nb;
    a = vy * 1024;
    b = vx * 1024;
    z = 0;
    if (vx == 0 && vy == 0) return 0;
    if (a < 0) begin
      t = a;
      if (b >= 0) begin
        a = b; b = -t; z = irdf_pkg::DEG90;
      end else begin
        a = -b; b = t; z = -irdf_pkg::DEG90;
      end
    end
    for (int k = 0; k < irdf_pkg::STEPS; k++) begin
      if (b >= 0) begin
        na = a + trunc_shr(b, k); nb = b - trunc_shr(a, k); z += irdf_pkg::ATN[k];
      end else begin
        na = a - trunc_shr(b, k); nb = b + trunc_shr(a, k); z -= irdf_pkg::ATN[k];
      end
      a = na;
      b = nb;
    end
    return clip(round_shr(z, 10), -irdf_pkg::ANGLE_MAX, irdf_pkg::ANGLE_MAX);
  endfunction

  // one sample tick; returns 1 with the heading when the window closes
  function automatic bit sample_tick(logic [irdf_pkg::LEVEL_W-1:0] lv, output heading_t h);
    longint sx, sy, vx, vy, best, limit;
    int cnt, best_i;
    sx = 0; sy = 0; best = 0; best_i = 0; cnt = 0;
    h = DARK;
    limit = window_len == 0 ? 1 : window_len;
    for (int i = 0; i < irdf_pkg::SENSORS_DEF; i++)
      if (!lv[i])
        pulse_widths[i] = clip(pulse_widths[i] + irdf_pkg::PULSE_STEP_DEF, 0, WIDTH_SAT);
    ticks_seen++;
    if (ticks_seen < limit) return 0;
    for (int i = 0; i < irdf_pkg::SENSORS_DEF; i++) begin
      if (pulse_widths[i] > 0) cnt++;
      if (pulse_widths[i] > best) begin
        best = pulse_widths[i];
        best_i = i;
      end
      sx += pulse_widths[i] * ring_x[i];
      sy += pulse_widths[i] * ring_y[i];
      pulse_widths[i] = 0;
    end
    ticks_seen = 0;
    vx = clip(round_shr(sx, 14), -irdf_pkg::VEC_MAX, irdf_pkg::VEC_MAX);
    vy = clip(round_shr(sy, 14), -irdf_pkg::VEC_MAX, irdf_pkg::VEC_MAX);
    h.active = irdf_pkg::ACTIVE_W'(cnt);
    h.sensor = irdf_pkg::IDX_W'(best_i);
    h.width = irdf_pkg::MAXW_W'(best);
    h.vx = irdf_pkg::VEC_W'(vx);
    h.vy = irdf_pkg::VEC_W'(vy);
    h.mag = irdf_pkg::MAG_W'(clip(sqrt_nearest(vx * vx + vy * vy), 0, irdf_pkg::MAG_MAX));
    h.ang = irdf_pkg::ANGLE_W'(bearing(vx, vy));
    return 1;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // result side
  always @(posedge clk) begin
    heading_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (heading_q.size() == 0) report("unexpected item", 1, 0);
      else begin
        w = heading_q.pop_front();
        if (out_if.active_count !== w.active) report("active_count", out_if.active_count, w.active);
        if (out_if.max_sensor !== w.sensor) report("max_sensor", out_if.max_sensor, w.sensor);
        if (out_if.max_width !== w.width) report("max_width", out_if.max_width, w.width);
        if (out_if.vector_x !== w.vx) report("vector_x", out_if.vector_x, w.vx);
        if (out_if.vector_y !== w.vy) report("vector_y", out_if.vector_y, w.vy);
        if (out_if.magnitude !== w.mag) report("magnitude", out_if.magnitude, w.mag);
        if (out_if.angle !== w.ang) report("angle", out_if.angle, w.ang);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        if ($urandom_range(0, 3) != 0) begin
          out_if.ready <= 1'b0;
          repeat (pick_gap() + 1) @(posedge clk);
        end
      end
    end
  end

  bit gaps_on = 1;

  task automatic offer(logic [irdf_pkg::LEVEL_W-1:0] lv, bit typed = 0, heading_t want = DARK);
    int g;
    heading_t h;
    g = gaps_on ? pick_gap() : 0;
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.sensor_levels <= lv;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (sample_tick(lv, h)) heading_q.push_back(typed ? want : h);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (heading_q.size() != 0) @(posedge clk);
    repeat (irdf_pkg::SENSORS_DEF + 40) @(posedge clk);
  endtask

  task automatic cfg_access(bit wr, logic [irdf_pkg::CFG_DATA_W-1:0] data,
                            output logic [irdf_pkg::CFG_DATA_W-1:0] rd);
    cfg_psel <= 1'b1;
    cfg_pwrite <= wr;
    cfg_paddr <= irdf_pkg::CFG_ADDR_W'(4 * irdf_pkg::REG_WINDOW);
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (wr) window_len = data[irdf_pkg::WINDOW_W-1:0];
  endtask

  task automatic set_window(int n);
    logic [irdf_pkg::CFG_DATA_W-1:0] rd;
    cfg_access(1, irdf_pkg::CFG_DATA_W'(n), rd);
    cfg_access(0, '0, rd);
    if (rd[irdf_pkg::WINDOW_W-1:0] !== irdf_pkg::WINDOW_W'(n)) report("window readback", rd, n);
  endtask

  function automatic logic [irdf_pkg::LEVEL_W-1:0] beam();
    logic [irdf_pkg::LEVEL_W-1:0] lv;
    int c, span;
    if ($urandom_range(0, 4) == 0) return irdf_pkg::LEVEL_W'($urandom());
    lv = '1;
    c = $urandom_range(0, irdf_pkg::SENSORS_DEF - 1);
    span = $urandom_range(1, 3);
    for (int i = 0; i < span; i++)
      lv[(c + i) % irdf_pkg::SENSORS_DEF] = $urandom_range(0, 5) == 0;
    return lv;
  endfunction

  row_t plan [] = '{
    '{16'hFFFF, 1, DARK},
    '{16'h0000, 0, DARK}, '{16'hFFFE, 0, DARK}, '{16'hFEFF, 0, DARK},
    '{16'hFFBF, 0, DARK}, '{16'h7FFF, 0, DARK}, '{16'hFFEF, 0, DARK},
    '{16'hEFFF, 0, DARK}, '{16'h0F0F, 0, DARK}, '{16'hF0F0, 0, DARK},
    '{16'hAAAA, 0, DARK}, '{16'h5555, 0, DARK}, '{16'hFF00, 0, DARK},
    '{16'h00FF, 0, DARK}, '{16'hFEFE, 0, DARK}, '{16'hFFFC, 0, DARK},
    '{16'h3FFF, 0, DARK}, '{16'hFFFF, 1, DARK}
  };

  initial begin
    logic [irdf_pkg::CFG_DATA_W-1:0] rd;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.sensor_levels <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    build_ring();
    for (int i = 0; i < irdf_pkg::SENSORS_MAX; i++) pulse_widths[i] = 0;
    ticks_seen = 0;
    window_len = irdf_pkg::WINDOW_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(0, '0, rd);
    if (rd[irdf_pkg::WINDOW_W-1:0] !== irdf_pkg::WINDOW_RESET)
      report("window after reset", rd, irdf_pkg::WINDOW_RESET);

    set_window(1);
    foreach (plan[i]) offer(plan[i].levels, plan[i].typed, plan[i].want);
    settle();

    // zero window acts as one tick
    set_window(0);
    repeat (4) offer(beam());
    settle();

    // shorten the window in mid-flight: next tick closes it
    set_window(12);
    repeat (5) offer(beam());
    settle();
    set_window(3);
    repeat (4) offer(beam());
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      set_window(ph == 0 ? 1 : $urandom_range(1, 16));
      gaps_on = ph != 3;
      if (ph == 2) hold_req = 1;
      repeat (140) offer(beam());
      settle();
    end
    gaps_on = 1;

    // longer window, sensor 3 held low so it carries the largest width
    set_window(100);
    repeat (100) offer(irdf_pkg::LEVEL_W'($urandom()) & 16'hFFF7);
    settle();

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
